// ===== src/uidol_pkg.sv =====
// Package for the unique-id ordered list: operation codes, field widths
// and the default capacity. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uidol_pkg;

  localparam int CapacityDefault = 64;

  localparam int FuncW  = 2;
  localparam int IdW    = 64;
  localparam int IndexW = 6;
  localparam int CountW = 7;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

endpackage

`default_nettype wire

// ===== src/uidol_if.sv =====
// Handshake channels of the unique-id ordered list: request and result.
// Depends on uidol_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface uidol_req_if
  import uidol_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [FuncW-1:0]    func;
  logic [IdW-1:0]      message_id;
  logic [IndexW-1:0]   index;

  modport source (output valid, func, message_id, index, input ready);
  modport sink   (input valid, func, message_id, index, output ready);
endinterface

interface uidol_rsp_if
  import uidol_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic                success;
  logic                list_full;
  logic [CountW-1:0]   entry_count;
  logic [IdW-1:0]      read_id;

  modport source (output valid, success, list_full, entry_count, read_id, input ready);
  modport sink   (input valid, success, list_full, entry_count, read_id, output ready);
endinterface

`default_nettype wire

// ===== src/unique_id_ordered_list.sv =====
// Top level of the unique-id ordered list: sequencer, entry memory and
// result register. Depends on uidol_pkg and the channels in uidol_if.
//
// Usage:
//   req (sink) carries one request: func (add, delete, clear, read),
//   message_id and index. It is taken when req.valid and req.ready are high.
//   rsp (source) returns exactly one result per request: success,
//   list_full, entry_count and read_id, taken on rsp.valid and rsp.ready.
// Cost of each request:
//   clear and read do not walk the list; add and delete search it.
//   A delete costs the same whatever the position of the match:
//   the search stops at the match and the gap closing moves only the
//   entries after it, so the two walks together cover the list once.
//   A delete that misses searches the whole list, as an add does. The
//   single read port of the entry memory sets the pace: the search
//   reads one entry a cycle and the gap closing moves one entry a
//   cycle. One request is in work at a time.
// Reset: the count goes to zero and no result is pending; the memory is
//   not cleared, since entries at or above the count are never read.
// Stall: the result register holds a finished result while rsp.ready is
//   low; the next request is taken and worked on meanwhile, and only its
//   own hand-over waits until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module unique_id_ordered_list
  import uidol_pkg::*;
#(
  parameter int CAPACITY = CapacityDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  uidol_req_if.sink   req,
  uidol_rsp_if.source rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Request held for the whole operation.
  func_e           op_q, op_d;
  logic [IdW-1:0]  key_q, key_d;

  // Entry count and walk pointers.
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   ptr_q, ptr_d;
  logic            pend_q, pend_d;      // a memory read was issued last cycle
  logic [CW-1:0]   pend_idx_q, pend_idx_d;

  // Outcome of the operation, waiting for the result register.
  logic            ok_q, ok_d;
  logic [IdW-1:0]  val_q, val_d;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic              out_ok_q;
  logic              out_full_q;
  logic [CountW-1:0] out_count_q;
  logic [IdW-1:0]    out_id_q;
  logic              out_load;

  // Entry memory, one write and one read port.
  logic [IdW-1:0]  mem_q [CAPACITY];
  logic [IdW-1:0]  rd_data_q;
  logic            we;
  logic [AW-1:0]   wa;
  logic [IdW-1:0]  wd;
  logic            re;
  logic [AW-1:0]   ra;

  logic                hit;
  logic [CW-1:0]       wr_m1;
  logic [AW+IndexW-1:0] idx_ext;
  logic [CW+IndexW-1:0] idx_cmp;
  logic [CW+IndexW-1:0] cnt_cmp;
  logic [CW+CountW-1:0] cnt_ext;

  assign req.ready = (state_q == S_IDLE);

  assign hit     = pend_q && (rd_data_q == key_q);
  assign wr_m1   = pend_idx_q - 1'b1;
  assign idx_ext = {{AW{1'b0}}, req.index};
  assign idx_cmp = {{CW{1'b0}}, req.index};
  assign cnt_cmp = {{IndexW{1'b0}}, count_q};
  assign cnt_ext = {{CountW{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rd_data_q <= mem_q[ra];
    end
  end

  // Sequencer: search one entry a cycle, then close the gap for a delete.
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    ok_d       = ok_q;
    val_d      = val_q;
    we         = 1'b0;
    wa         = count_q[AW-1:0];
    wd         = key_q;
    re         = 1'b0;
    ra         = ptr_q[AW-1:0];
    out_load   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          op_d  = func_e'(req.func);
          key_d = req.message_id;
          ptr_d = '0;
          ok_d  = 1'b0;
          val_d = '0;
          case (func_e'(req.func))
            FUNC_ADD, FUNC_DELETE: begin
              state_d = S_SCAN;
            end
            FUNC_CLEAR: begin
              count_d = '0;
              ok_d    = 1'b1;
              state_d = S_DONE;
            end
            FUNC_READ: begin
              if (idx_cmp < cnt_cmp) begin
                re      = 1'b1;
                ra      = idx_ext[AW-1:0];
                state_d = S_READ;
              end else begin
                state_d = S_DONE;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          if (op_q == FUNC_DELETE) begin
            // Move every later entry down by one.
            ptr_d   = pend_idx_q + 1'b1;
            state_d = S_SHIFT;
          end else begin
            state_d = S_DONE;  // duplicate add fails
          end
        end else if (ptr_q == count_q) begin
          // Whole list searched without a match.
          if (op_q == FUNC_ADD && count_q < CW'(CAPACITY)) begin
            we      = 1'b1;
            wa      = count_q[AW-1:0];
            wd      = key_q;
            count_d = count_q + 1'b1;
            ok_d    = 1'b1;
          end
          state_d = S_DONE;
        end else begin
          re         = 1'b1;
          ra         = ptr_q[AW-1:0];
          pend_d     = 1'b1;
          pend_idx_d = ptr_q;
          ptr_d      = ptr_q + 1'b1;
        end
      end

      S_SHIFT: begin
        if (pend_q) begin
          we = 1'b1;
          wa = wr_m1[AW-1:0];
          wd = rd_data_q;
        end
        if (ptr_q < count_q) begin
          re         = 1'b1;
          ra         = ptr_q[AW-1:0];
          pend_d     = 1'b1;
          pend_idx_d = ptr_q;
          ptr_d      = ptr_q + 1'b1;
        end else if (!pend_q) begin
          count_d = count_q - 1'b1;
          ok_d    = 1'b1;
          state_d = S_DONE;
        end
      end

      S_READ: begin
        val_d   = rd_data_q;
        ok_d    = 1'b1;
        state_d = S_DONE;
      end

      S_DONE: begin
        // Hold until the result register is free.
        if (!out_valid_q || rsp.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !rsp.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    ptr_q      <= ptr_d;
    pend_idx_q <= pend_idx_d;
    ok_q       <= ok_d;
    val_q      <= val_d;
    if (out_load) begin
      out_ok_q    <= ok_q;
      out_full_q  <= (count_q == CW'(CAPACITY));
      out_count_q <= cnt_ext[CountW-1:0];
      out_id_q    <= val_q;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.success     = out_ok_q;
  assign rsp.list_full   = out_full_q;
  assign rsp.entry_count = out_count_q;
  assign rsp.read_id     = out_id_q;

  // Count never runs past the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Gap closing reads only inside the held entries and never position 0.
  a_shift_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT |-> (ptr_q <= count_q) && (ptr_q != '0))
    else $error("shift pointer out of range");

  // A moved entry lands below the last held position.
  a_shift_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && pend_q) |-> (pend_idx_q < count_q) && (pend_idx_q != '0))
    else $error("shift write outside held entries");

endmodule

`default_nettype wire

// ===== tb/sv/uidol_list_checker.sv =====
// Scoreboard for the unique-id ordered list: mirrors the list, predicts one
// result per accepted request and compares it with the returned result.
// Depends on uidol_pkg and the channels in uidol_if.
`timescale 1ns / 1ps

module uidol_list_checker
  import uidol_pkg::*;
#(
  parameter int CAPACITY = CapacityDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  uidol_req_if  req,
  uidol_rsp_if  rsp,
  output int    fail_count_o,
  output int    pending_o
);

  typedef struct packed {
    logic              success;
    logic              list_full;
    logic [CountW-1:0] entry_count;
    logic [IdW-1:0]    read_id;
  } list_result_t;

  logic [IdW-1:0] id_list [CAPACITY];
  int             held_count;
  list_result_t   awaited_results [$];
  int             mismatch_count;

  // Position of the first matching entry, or held_count when absent.
  function automatic int find_slot(logic [IdW-1:0] key);
    for (int i = 0; i < held_count; i++) begin
      if (id_list[i] == key) return i;
    end
    return held_count;
  endfunction

  // Apply one request to the mirrored list and return its result.
  function automatic list_result_t apply_request(func_e op, logic [IdW-1:0] key,
                                                 logic [IndexW-1:0] pos);
    list_result_t res;
    int           at;
    res = '0;
    case (op)
      FUNC_ADD: begin
        at = find_slot(key);
        if (at == held_count && held_count < CAPACITY) begin
          id_list[held_count] = key;
          held_count++;
          res.success = 1'b1;
        end
      end
      FUNC_DELETE: begin
        at = find_slot(key);
        if (at < held_count) begin
          // close the gap, keep order
          for (int j = at; j + 1 < held_count; j++) id_list[j] = id_list[j + 1];
          held_count--;
          res.success = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        held_count  = 0;
        res.success = 1'b1;
      end
      default: begin
        if (int'(pos) < held_count && int'(pos) < CAPACITY) begin
          res.read_id = id_list[pos];
          res.success = 1'b1;
        end
      end
    endcase
    res.list_full   = (held_count >= CAPACITY);
    res.entry_count = CountW'(held_count);
    return res;
  endfunction

  task automatic check_field(string label, logic [IdW-1:0] want, logic [IdW-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      awaited_results.delete();
      held_count     = 0;
      mismatch_count = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
    end else begin
      // results first: a result at this edge belongs to an older request
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none expected, expected nothing, actual %b/%b/%0d/0x%0h",
                   $time, rsp.success, rsp.list_full, rsp.entry_count, rsp.read_id);
        end else begin
          want = awaited_results.pop_front();
          check_field("success", IdW'(want.success), IdW'(rsp.success));
          check_field("list_full", IdW'(want.list_full), IdW'(rsp.list_full));
          check_field("entry_count", IdW'(want.entry_count), IdW'(rsp.entry_count));
          check_field("read_id", want.read_id, rsp.read_id);
        end
      end
      if (req.valid && req.ready)
        awaited_results.push_back(apply_request(func_e'(req.func), req.message_id, req.index));
      fail_count_o <= mismatch_count;
      pending_o    <= awaited_results.size();
    end
  end

endmodule

// ===== tb/sv/tb_unique_id_ordered_list.sv =====
// Testbench top for the unique-id ordered list: clock, reset, request
// stimulus, result acceptance and verdict. Depends on uidol_pkg, uidol_if,
// the list itself and uidol_list_checker.
`timescale 1ns / 1ps

module tb_unique_id_ordered_list;
  import uidol_pkg::*;

  localparam int     Capacity    = CapacityDefault;
  localparam int     HalfNs      = 5;
  localparam int     ItemTarget  = 1050;
  // worst request is a delete that hits in a full list
  localparam int     DrainCycles = 2 * Capacity + 32;
  localparam int     HoldCycles  = 600;
  localparam int     HoldAfter   = 300;
  localparam longint LimitNs     = 64'd10_000_000;

  logic clk_i;
  logic rst_ni;

  uidol_req_if req_if ();
  uidol_rsp_if rsp_if ();

  int fail_count;
  int pending_count;

  // progress counters for the summary
  int sent_total;
  int taken_total;
  int op_count [4];

  // idling style per side: 0 no gaps, 1 uniform random gaps, 2 rare gaps
  int send_mode;
  int take_mode;

  // long result stall, counted in its own process
  logic rsp_hold;

  // identifiers already offered for adding, used for duplicates and deletes
  logic [IdW-1:0] known_ids [$];

  unique_id_ordered_list #(
    .CAPACITY (Capacity)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if.sink),
    .rsp    (rsp_if.source)
  );

  uidol_list_checker #(
    .CAPACITY (Capacity)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_if),
    .rsp          (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always begin
    clk_i = 1'b1;
    #HalfNs;
    clk_i = 1'b0;
    #HalfNs;
  end

  function automatic int draw_gap(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 8);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0;
  endfunction

  function automatic logic [IdW-1:0] fresh_id();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [IndexW-1:0] any_index();
    return IndexW'($urandom_range(0, 63));
  endfunction

  // Pick a previously offered identifier; fall back to a fresh one.
  function automatic logic [IdW-1:0] known_id();
    if (known_ids.size() == 0) return fresh_id();
    return known_ids[$urandom_range(0, known_ids.size() - 1)];
  endfunction

  // Offer one request and hold it until the list takes it. Valid stays
  // high across back-to-back requests; it only drops for a drawn gap.
  task automatic send_request(func_e op, logic [IdW-1:0] key, logic [IndexW-1:0] pos);
    int gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= op;
    req_if.message_id <= key;
    req_if.index      <= pos;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent_total++;
    op_count[int'(op)]++;
    if ($urandom_range(0, 49) == 0) send_mode = $urandom_range(0, 2);
  endtask

  // Add a new random identifier and remember it for later hits.
  task automatic add_fresh();
    logic [IdW-1:0] key;
    key = fresh_id();
    known_ids.push_back(key);
    if (known_ids.size() > 96) void'(known_ids.pop_front());
    send_request(FUNC_ADD, key, any_index());
  endtask

  // Result side: accept results with random gaps, and stay low for the
  // whole long stall while it is active.
  initial begin
    int gap;
    rsp_if.ready <= 1'b0;
    take_mode    = 1;
    taken_total  = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_gap(take_mode);
      if (gap > 0 || rsp_hold) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        while (rsp_hold) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      taken_total++;
      if ($urandom_range(0, 39) == 0) take_mode = $urandom_range(0, 2);
    end
  end

  // Stall results for a long stretch while requests keep coming, so the
  // result register and the request in work both back up into req.ready.
  initial begin
    rsp_hold <= 1'b0;
    wait (sent_total >= HoldAfter);
    @(posedge clk_i);
    rsp_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rsp_hold <= 1'b0;
  end

  initial begin
    #LimitNs;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int roll;
    int phase_kind;
    sent_total = 0;
    send_mode  = 0;
    for (int k = 0; k < 4; k++) op_count[k] = 0;

    // every input known from time zero, then a reset
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.func       <= FUNC_ADD;
    req_if.message_id <= '0;
    req_if.index      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty list corners, identifier extremes, duplicates,
    // misses, deletes at head, middle and tail, and index extremes.
    send_request(FUNC_CLEAR, fresh_id(), any_index());         // clear while empty
    send_request(FUNC_READ, fresh_id(), IndexW'(0));            // read on empty list
    send_request(FUNC_DELETE, '0, any_index());                  // delete from empty list
    send_request(FUNC_ADD, '0, any_index());
    send_request(FUNC_ADD, '1, any_index());
    send_request(FUNC_ADD, '0, any_index());                     // duplicate add
    send_request(FUNC_ADD, {(IdW/2){2'b01}}, any_index());
    send_request(FUNC_ADD, {(IdW/2){2'b10}}, any_index());
    send_request(FUNC_READ, fresh_id(), IndexW'(0));
    send_request(FUNC_READ, fresh_id(), IndexW'(1));
    send_request(FUNC_READ, fresh_id(), IndexW'(3));
    send_request(FUNC_READ, fresh_id(), IndexW'(4));            // just past the count
    send_request(FUNC_READ, fresh_id(), '1);                     // highest index
    send_request(FUNC_DELETE, '1, any_index());                  // middle, shifts the rest
    send_request(FUNC_READ, fresh_id(), IndexW'(1));
    send_request(FUNC_DELETE, '0, any_index());                  // head
    send_request(FUNC_DELETE, '0, any_index());                  // now absent
    send_request(FUNC_DELETE, {(IdW/2){2'b10}}, any_index());    // tail
    send_request(FUNC_READ, fresh_id(), IndexW'(0));
    send_request(FUNC_CLEAR, fresh_id(), any_index());          // clear a non-empty list
    send_request(FUNC_READ, fresh_id(), IndexW'(0));

    // Random part in phases: grow runs fill the list to full and push adds
    // against it, churn runs mix hits and misses, noise runs are unshaped.
    while (sent_total < ItemTarget) begin
      phase_kind = $urandom_range(0, 7);
      if (phase_kind < 3) begin
        if ($urandom_range(0, 1) == 1) send_request(FUNC_CLEAR, fresh_id(), any_index());
        repeat ($urandom_range(80, 100)) begin
          roll = $urandom_range(0, 99);
          if (roll < 85) add_fresh();
          else if (roll < 90) send_request(FUNC_ADD, known_id(), any_index());
          else send_request(FUNC_READ, fresh_id(), any_index());
        end
      end else if (phase_kind < 7) begin
        repeat ($urandom_range(40, 80)) begin
          roll = $urandom_range(0, 99);
          if (roll < 30) add_fresh();
          else if (roll < 40) send_request(FUNC_ADD, known_id(), any_index());
          else if (roll < 70) send_request(FUNC_DELETE, known_id(), any_index());
          else if (roll < 75) send_request(FUNC_DELETE, fresh_id(), any_index());
          else if (roll < 97) send_request(FUNC_READ, fresh_id(), any_index());
          else send_request(FUNC_CLEAR, fresh_id(), any_index());
        end
      end else begin
        repeat (20) begin
          send_request(func_e'($urandom_range(0, 3)), fresh_id(), any_index());
        end
      end
    end
    req_if.valid <= 1'b0;

    // let the checker see the last request, then drain the results
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d requests (%0d add, %0d delete, %0d clear, %0d read), %0d results taken,",
             sent_total, op_count[FUNC_ADD], op_count[FUNC_DELETE], op_count[FUNC_CLEAR],
             op_count[FUNC_READ], taken_total);
    $display("with fills to capacity %0d and a %0d-cycle result stall.", Capacity, HoldCycles);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/uidol_pkg.sv
src/uidol_if.sv
src/unique_id_ordered_list.sv
tb/sv/uidol_list_checker.sv
tb/sv/tb_unique_id_ordered_list.sv
